/* src/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants of the sine source
// Fixed-point constants, the arctangent table, the register map and the
// pipeline stage records.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
    localparam logic [21:0] INV_TWO_PI = 22'd2670176;
    localparam logic [18:0] HALF_PI_Q16 = 19'd102944;
    localparam logic [18:0] THREE_HALF_PI_Q16 = 19'd308831;
    localparam logic signed [19:0] PI_Q16 = 20'sd205887;
    localparam logic signed [19:0] TWO_PI_Q16 = 20'sd411775;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [17:0] DIV3_MUL = 18'd174763;

    localparam logic signed [19:0] ATAN_Q16 [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150,
        20'sd4091, 20'sd2047, 20'sd1024, 20'sd512,
        20'sd256, 20'sd128, 20'sd64, 20'sd32,
        20'sd16, 20'sd8, 20'sd4, 20'sd2
    };

    typedef enum logic [1:0] {
        REG_AMPLITUDE         = 2'd0,
        REG_ANGULAR_FREQUENCY = 2'd1,
        REG_PHASE_OFFSET      = 2'd2,
        REG_ORDER             = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic               valid;
        logic [31:0]        t;
        logic [23:0]        w;
        logic signed [19:0] phi;
        logic [15:0]        a;
        logic [2:0]         ord;
        logic               aneg;
        logic [15:0]        am;
        logic [47:0]        k0;
        logic [47:0]        k1;
        logic [47:0]        k2;
        logic [47:0]        k3;
        logic [39:0]        kf;
        logic [55:0]        prod;
        logic [55:0]        kraw;
        logic [21:0]        q;
        logic [36:0]        r;
        logic signed [37:0] s;
        logic [55:0]        xlo;
        logic [31:0]        xhi;
        logic [47:0]        zq;
        logic [1:0]         rem;
        logic [18:0]        ph;
        logic signed [19:0] z;
        logic               flip;
    } pipe_t;

    typedef struct packed {
        logic               valid;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [19:0] z;
        logic               flip;
        logic               aneg;
        logic [2:0]         ord;
        logic [3:0][47:0]   k;
    } cordic_t;

    typedef struct packed {
        logic             valid;
        logic [2:0]       ord;
        logic [3:0]       neg;
        logic [31:0]      mag_s;
        logic [31:0]      mag_c;
        logic [3:0][47:0] k;
        logic [3:0][63:0] lo;
        logic [3:0][47:0] hi;
        logic [3:0][79:0] sum;
        logic [3:0][50:0] m;
    } tail_t;

    // {quotient, remainder} of an 18-bit value below three times 2^16
    function automatic logic [17:0] div3(input logic [17:0] v);
        logic [35:0] prod;
        logic [15:0] qd;
        logic [17:0] rd;
        prod = 36'(v) * 36'(DIV3_MUL);
        qd = prod[34:19];
        rd = v - 18'({qd, 1'b0}) - 18'(qd);
        return {qd, rd[1:0]};
    endfunction

endpackage

/* src/sine_source_with_derivatives.sv */
// ----------------------------------------------------------------------------
// sine_source_with_derivatives: sine source with scaled Taylor terms
// Phase reduction, 16-stage CORDIC and fixed-point term scaling, fully
// pipelined.
// ----------------------------------------------------------------------------
//  channel   signals                                         transfer
//  input     start, busy, sample_time                        start && !busy
//  result    done, value, first_derivative, second_term,     done
//            third_term
//  config    cfg_write, cfg_index, cfg_data                  cfg_write
//
//  One item enters per cycle; busy stays low. Each result passes nine
//  reduction stages, seventeen CORDIC stages, four scaling stages and an
//  output register. Reset clears valid bits and loads register defaults.
//  The receiver cannot stall, so the pipeline always advances.
// ----------------------------------------------------------------------------
module sine_source_with_derivatives (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        sample_time,
    output logic               done,
    output logic signed [31:0] value,
    output logic signed [31:0] first_derivative,
    output logic signed [31:0] second_term,
    output logic signed [31:0] third_term,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    logic [15:0] amplitude_reg, amplitude_next;
    logic [23:0] freq_reg, freq_next;
    logic [19:0] phase_reg, phase_next;
    logic [2:0]  order_reg, order_next;

    ssd_pkg::pipe_t e1_reg, e2_reg, e3_reg, e4_reg, e5_reg, e6_reg, e7_reg, e8_reg, e9_reg;
    ssd_pkg::pipe_t e1_next, e2_next, e3_next, e4_next, e5_next, e6_next, e7_next, e8_next;
    ssd_pkg::pipe_t e9_next;
    ssd_pkg::cordic_t c_reg [ssd_pkg::CORDIC_STEPS + 1];
    ssd_pkg::cordic_t c_next [ssd_pkg::CORDIC_STEPS + 1];
    ssd_pkg::tail_t t1_reg, t2_reg, t3_reg, t4_reg;
    ssd_pkg::tail_t t1_next, t2_next, t3_next, t4_next;

    logic               done_reg;
    logic [3:0][31:0]   res_reg, res_next;

    assign busy = 1'b0;
    assign done = done_reg;
    assign value = $signed(res_reg[0]);
    assign first_derivative = $signed(res_reg[1]);
    assign second_term = $signed(res_reg[2]);
    assign third_term = $signed(res_reg[3]);

    function automatic ssd_pkg::cordic_t cordic_step(input ssd_pkg::cordic_t c, input int i);
        ssd_pkg::cordic_t n;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        n = c;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (!c.z[19])
        begin
            n.x = c.x - dx;
            n.y = c.y + dy;
            n.z = c.z - ssd_pkg::ATAN_Q16[i];
        end
        else
        begin
            n.x = c.x + dx;
            n.y = c.y - dy;
            n.z = c.z + ssd_pkg::ATAN_Q16[i];
        end
        return n;
    endfunction

    always_comb
    begin
        amplitude_next = amplitude_reg;
        freq_next = freq_reg;
        phase_next = phase_reg;
        order_next = order_reg;
        if (cfg_write)
        begin
            case (ssd_pkg::reg_index_t'(cfg_index))
                ssd_pkg::REG_AMPLITUDE:         amplitude_next = cfg_data[15:0];
                ssd_pkg::REG_ANGULAR_FREQUENCY: freq_next = cfg_data;
                ssd_pkg::REG_PHASE_OFFSET:      phase_next = cfg_data[19:0];
                ssd_pkg::REG_ORDER:             order_next = cfg_data[2:0];
                default:                        amplitude_next = amplitude_reg;
            endcase
        end
    end

    always_comb
    begin
        e1_next = '0;
        e1_next.valid = start && !busy;
        e1_next.t = sample_time;
        e1_next.w = freq_next;
        e1_next.phi = $signed(phase_next);
        e1_next.a = amplitude_next;
        e1_next.ord = order_next;
    end

    always_comb
    begin
        e2_next = e1_reg;
        e2_next.aneg = e1_reg.a[15];
        e2_next.am = e1_reg.a[15] ? 16'(~e1_reg.a + 16'd1) : e1_reg.a;
        e2_next.k0 = {24'b0, e2_next.am, 8'b0};
        e2_next.prod = 56'(e1_reg.w) * 56'(e1_reg.t);
        e2_next.kraw = 56'(e2_next.am) * 56'(e1_reg.w);
    end

    always_comb
    begin
        logic [45:0] qprod;
        e3_next = e2_reg;
        qprod = 46'(e2_reg.prod[55:32]) * 46'(ssd_pkg::INV_TWO_PI);
        e3_next.q = qprod[45:24];
        e3_next.k1 = 48'((e2_reg.kraw[39:0] + 40'd128) >> 8);
    end

    always_comb
    begin
        logic [56:0] qt;
        e4_next = e3_reg;
        qt = 57'(e3_reg.q) * 57'(ssd_pkg::TWO_PI_Q32);
        e4_next.r = e3_reg.prod[36:0] - qt[36:0];
        e4_next.kraw = 56'(e3_reg.k1[31:0]) * 56'(e3_reg.w);
    end

    always_comb
    begin
        e5_next = e4_reg;
        if (e4_reg.r >= {1'b0, ssd_pkg::TWO_PI_Q32, 1'b0})
        begin
            e5_next.r = e4_reg.r - {1'b0, ssd_pkg::TWO_PI_Q32, 1'b0};
        end
        else if (e4_reg.r >= {2'b0, ssd_pkg::TWO_PI_Q32})
        begin
            e5_next.r = e4_reg.r - {2'b0, ssd_pkg::TWO_PI_Q32};
        end
        e5_next.k2 = 48'((e4_reg.kraw + 56'd65536) >> 17);
        e5_next.kf = 40'((e4_reg.kraw + 56'd32768) >> 16);
    end

    always_comb
    begin
        e6_next = e5_reg;
        e6_next.s = $signed({3'b000, e5_reg.r[34:0]})
                  + $signed({{2{e5_reg.phi[19]}}, e5_reg.phi, 16'b0});
        e6_next.xlo = 56'(e5_reg.kf[31:0]) * 56'(e5_reg.w);
        e6_next.xhi = 32'(e5_reg.kf[39:32]) * 32'(e5_reg.w);
    end

    always_comb
    begin
        logic signed [38:0] sv, tq, t2q, sp1, sp2, sm1, sm2, wr;
        logic [63:0] sum64;
        e7_next = e6_reg;
        tq = $signed({4'b0, ssd_pkg::TWO_PI_Q32});
        t2q = $signed({3'b0, ssd_pkg::TWO_PI_Q32, 1'b0});
        sv = $signed({e6_reg.s[37], e6_reg.s});
        sp1 = sv + tq;
        sp2 = sv + t2q;
        sm1 = sv - tq;
        sm2 = sv - t2q;
        if (sv < 0)
        begin
            wr = (sp1 < 0) ? sp2 : sp1;
        end
        else if (sv >= t2q)
        begin
            wr = sm2;
        end
        else if (sv >= tq)
        begin
            wr = sm1;
        end
        else
        begin
            wr = sv;
        end
        e7_next.ph = wr[34:16];
        sum64 = {e6_reg.xhi, 32'b0} + {8'b0, e6_reg.xlo} + 64'd196608;
        e7_next.zq = {1'b0, sum64[63:17]};
    end

    always_comb
    begin
        logic [17:0] d;
        e8_next = e7_reg;
        if (e7_reg.ph <= ssd_pkg::HALF_PI_Q16)
        begin
            e8_next.z = $signed({1'b0, e7_reg.ph});
            e8_next.flip = 1'b0;
        end
        else if (e7_reg.ph < ssd_pkg::THREE_HALF_PI_Q16)
        begin
            e8_next.z = $signed({1'b0, e7_reg.ph}) - ssd_pkg::PI_Q16;
            e8_next.flip = 1'b1;
        end
        else
        begin
            e8_next.z = $signed({1'b0, e7_reg.ph}) - ssd_pkg::TWO_PI_Q16;
            e8_next.flip = 1'b0;
        end
        d = ssd_pkg::div3({2'b00, e7_reg.zq[47:32]});
        e8_next.k3[47:32] = d[17:2];
        e8_next.rem = d[1:0];
    end

    always_comb
    begin
        logic [17:0] d;
        e9_next = e8_reg;
        d = ssd_pkg::div3({e8_reg.rem, e8_reg.zq[31:16]});
        e9_next.k3[31:16] = d[17:2];
        e9_next.rem = d[1:0];
    end

    always_comb
    begin
        logic [17:0] d;
        d = ssd_pkg::div3({e9_reg.rem, e9_reg.zq[15:0]});
        c_next[0].valid = e9_reg.valid;
        c_next[0].x = ssd_pkg::CORDIC_GAIN_Q30;
        c_next[0].y = '0;
        c_next[0].z = e9_reg.z;
        c_next[0].flip = e9_reg.flip;
        c_next[0].aneg = e9_reg.aneg;
        c_next[0].ord = e9_reg.ord;
        c_next[0].k[0] = e9_reg.k0;
        c_next[0].k[1] = e9_reg.k1;
        c_next[0].k[2] = e9_reg.k2;
        c_next[0].k[3] = {e9_reg.k3[47:16], d[17:2]};
        for (int i = 0; i < ssd_pkg::CORDIC_STEPS; i++)
        begin
            c_next[i + 1] = cordic_step(c_reg[i], i);
        end
    end

    always_comb
    begin
        ssd_pkg::cordic_t c;
        logic [33:0] ymag, xmag;
        logic sy, sx;
        c = c_reg[ssd_pkg::CORDIC_STEPS];
        ymag = c.y[33] ? 34'(-c.y) : 34'(c.y);
        xmag = c.x[33] ? 34'(-c.x) : 34'(c.x);
        sy = c.flip ? (!c.y[33] && (c.y != 0)) : c.y[33];
        sx = c.flip ? (!c.x[33] && (c.x != 0)) : c.x[33];
        t1_next = '0;
        t1_next.valid = c.valid;
        t1_next.ord = c.ord;
        t1_next.mag_s = ymag[31:0];
        t1_next.mag_c = xmag[31:0];
        t1_next.neg = {c.aneg == sx, c.aneg == sy, c.aneg != sx, c.aneg != sy};
        t1_next.k = c.k;
    end

    always_comb
    begin
        logic [31:0] mag;
        t2_next = t1_reg;
        for (int j = 0; j < 4; j++)
        begin
            mag = (j == 0 || j == 2) ? t1_reg.mag_s : t1_reg.mag_c;
            t2_next.lo[j] = 64'(t1_reg.k[j][31:0]) * 64'(mag);
            t2_next.hi[j] = 48'(t1_reg.k[j][47:32]) * 48'(mag);
        end
    end

    always_comb
    begin
        t3_next = t2_reg;
        for (int j = 0; j < 4; j++)
        begin
            t3_next.sum[j] = {t2_reg.hi[j], 32'b0} + 80'(t2_reg.lo[j]);
        end
    end

    always_comb
    begin
        t4_next = t3_reg;
        for (int j = 0; j < 4; j++)
        begin
            t4_next.m[j] = 51'(t3_reg.sum[j][79:30]) + 51'(t3_reg.sum[j][29]);
        end
    end

    always_comb
    begin
        logic [3:0] en;
        en = {t4_reg.ord >= 3'd4, t4_reg.ord >= 3'd3, t4_reg.ord >= 3'd2, 1'b1};
        for (int j = 0; j < 4; j++)
        begin
            if (!en[j])
            begin
                res_next[j] = '0;
            end
            else if (t4_reg.neg[j])
            begin
                res_next[j] = (t4_reg.m[j] >= 51'h80000000) ? 32'h80000000
                                                            : 32'(~t4_reg.m[j] + 51'd1);
            end
            else
            begin
                res_next[j] = (t4_reg.m[j] > 51'h7FFFFFFF) ? 32'h7FFFFFFF
                                                           : t4_reg.m[j][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= 16'd256;
            freq_reg <= 24'd102944;
            phase_reg <= 20'd0;
            order_reg <= 3'd1;
            e1_reg.valid <= 1'b0;
            e2_reg.valid <= 1'b0;
            e3_reg.valid <= 1'b0;
            e4_reg.valid <= 1'b0;
            e5_reg.valid <= 1'b0;
            e6_reg.valid <= 1'b0;
            e7_reg.valid <= 1'b0;
            e8_reg.valid <= 1'b0;
            e9_reg.valid <= 1'b0;
            for (int i = 0; i <= ssd_pkg::CORDIC_STEPS; i++)
            begin
                c_reg[i].valid <= 1'b0;
            end
            t1_reg.valid <= 1'b0;
            t2_reg.valid <= 1'b0;
            t3_reg.valid <= 1'b0;
            t4_reg.valid <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            amplitude_reg <= amplitude_next;
            freq_reg <= freq_next;
            phase_reg <= phase_next;
            order_reg <= order_next;
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            e3_reg <= e3_next;
            e4_reg <= e4_next;
            e5_reg <= e5_next;
            e6_reg <= e6_next;
            e7_reg <= e7_next;
            e8_reg <= e8_next;
            e9_reg <= e9_next;
            for (int i = 0; i <= ssd_pkg::CORDIC_STEPS; i++)
            begin
                c_reg[i] <= c_next[i];
            end
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            t3_reg <= t3_next;
            t4_reg <= t4_next;
            done_reg <= t4_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

/* tb/sv/tb_sine_source_with_derivatives.sv */
// ----------------------------------------------------------------------------
// tb_sine_source_with_derivatives: self-checking bench of the sine source
// Drives a directed table of time stamps and then random ones under several
// register settings, predicts each result with a local integer CORDIC model
// and compares every strobed result field by field against the oldest
// expectation.
// ----------------------------------------------------------------------------
module tb_sine_source_with_derivatives;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] val;
        logic signed [31:0] d1;
        logic signed [31:0] d2;
        logic signed [31:0] d3;
    } sine_terms_t;

    typedef struct {
        logic [31:0] t;
        logic        known;
        sine_terms_t res;
    } table_row_t;

    logic                ss_clk_unused_guard;
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [31:0]         sample_time = '0;
    logic                done;
    logic signed [31:0]  value;
    logic signed [31:0]  first_derivative;
    logic signed [31:0]  second_term;
    logic signed [31:0]  third_term;
    logic                cfg_write = 1'b0;
    ssd_pkg::reg_index_t cfg_index = ssd_pkg::REG_AMPLITUDE;
    logic [23:0]         cfg_data = '0;

    logic [15:0] amp_reg;
    logic [23:0] freq_reg;
    logic [19:0] phase_reg;
    logic [2:0]  order_reg;

    sine_terms_t pending_terms[$];
    int          errors = 0;
    longint      cycles = 0;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int     LATENCY = 30;

    assign ss_clk_unused_guard = clk;

    sine_source_with_derivatives i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_time(sample_time), .done(done), .value(value),
        .first_derivative(first_derivative), .second_term(second_term),
        .third_term(third_term), .cfg_write(cfg_write),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic signed [63:0] shift_down(logic signed [63:0] v, int sh);
        return v >>> sh;
    endfunction

    function automatic logic [31:0] scale_term(logic [63:0] k, logic [63:0] mag, logic neg);
        logic [127:0] p;
        logic [127:0] m;
        p = 128'(k) * 128'(mag);
        m = (p >> 30) + ((p >> 29) & 128'd1);
        if (neg)
        begin
            if (m >= 128'h8000_0000)
                return 32'h8000_0000;
            return 32'(-m);
        end
        if (m > 128'h7FFF_FFFF)
            return 32'h7FFF_FFFF;
        return 32'(m);
    endfunction

    function automatic sine_terms_t sine_predict(logic [31:0] t);
        sine_terms_t r;
        logic [63:0] w, am, k0, k1, k2, k2f, k3, sm, cm;
        logic signed [63:0] a, phi, s, ph, z, x, y, dx, dy;
        logic flip, aneg;
        w = 64'(freq_reg);
        a = 64'(signed'(amp_reg));
        phi = 64'(signed'(phase_reg));
        flip = 1'b0;
        aneg = a < 0;
        am = aneg ? 64'(-a) : 64'(a);
        s = signed'((w * 64'(t)) % 64'd26986075409) + phi * 65536;
        for (int i = 0; i < 2; i++)
        begin
            if (s < 0)
                s += 64'sd26986075409;
            if (s >= 64'sd26986075409)
                s -= 64'sd26986075409;
        end
        ph = s >>> 16;
        if (ph <= 102944)
            z = ph;
        else if (ph < 308831)
        begin
            z = ph - 205887;
            flip = 1'b1;
        end
        else
            z = ph - 411775;
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = shift_down(y, i);
            dy = shift_down(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= 64'(ssd_pkg::ATAN_Q16[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += 64'(ssd_pkg::ATAN_Q16[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        sm = y < 0 ? 64'(-y) : 64'(y);
        cm = x < 0 ? 64'(-x) : 64'(x);
        k0 = am << 8;
        k1 = (am * w + 128) >> 8;
        k2 = (k1 * w + (64'd1 << 16)) >> 17;
        k2f = (k1 * w + (64'd1 << 15)) >> 16;
        k3 = (k2f * w + 3 * 65536) / (6 * 65536);
        r.val = scale_term(k0, sm, aneg != (y < 0));
        r.d1 = 0;
        r.d2 = 0;
        r.d3 = 0;
        if (order_reg >= 2)
            r.d1 = scale_term(k1, cm, aneg != (x < 0));
        if (order_reg >= 3)
            r.d2 = scale_term(k2, sm, aneg == (y < 0));
        if (order_reg >= 4)
            r.d3 = scale_term(k3, cm, aneg == (x < 0));
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_terms.size() == 0)
            begin
                $display("%0t unexpected result value=%0d", $realtime, value);
                errors++;
            end
            else
            begin
                sine_terms_t e;
                e = pending_terms.pop_front();
                if (value !== e.val)
                begin
                    $display("%0t value exp %0d got %0d", $realtime, e.val, value);
                    errors++;
                end
                if (first_derivative !== e.d1)
                begin
                    $display("%0t first_derivative exp %0d got %0d", $realtime, e.d1,
                             first_derivative);
                    errors++;
                end
                if (second_term !== e.d2)
                begin
                    $display("%0t second_term exp %0d got %0d", $realtime, e.d2,
                             second_term);
                    errors++;
                end
                if (third_term !== e.d3)
                begin
                    $display("%0t third_term exp %0d got %0d", $realtime, e.d3,
                             third_term);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(ssd_pkg::reg_index_t idx, logic [23:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            ssd_pkg::REG_AMPLITUDE:         amp_reg = data[15:0];
            ssd_pkg::REG_ANGULAR_FREQUENCY: freq_reg = data;
            ssd_pkg::REG_PHASE_OFFSET:      phase_reg = data[19:0];
            ssd_pkg::REG_ORDER:             order_reg = data[2:0];
            default:                        ;
        endcase
    endtask

    // drive one transfer; the caller is at a falling edge
    task automatic send_time(logic [31:0] t, logic known, sine_terms_t res);
        start <= 1'b1;
        sample_time <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_terms.push_back(known ? res : sine_predict(t));
        @(negedge clk);
    endtask

    task automatic idle_gap(bit allow);
        int n;
        if (allow && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 19);
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_terms.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic random_burst(int n, bit gaps);
        sine_terms_t none;
        none = '{default: 0};
        for (int i = 0; i < n; i++)
        begin
            logic [31:0] t;
            case ($urandom_range(0, 3))
                0:       t = $urandom_range(0, 65535 * 8);
                1:       t = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
                default: t = $urandom;
            endcase
            send_time(t, 1'b0, none);
            idle_gap(gaps);
        end
    endtask

    table_row_t directed[$];

    initial
    begin
        sine_terms_t none;
        none = '{default: 0};
        amp_reg = 16'd256;
        freq_reg = 24'd102944;
        phase_reg = 20'd0;
        order_reg = 3'd1;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // after reset: a table of time stamps, value term only
        directed.push_back('{32'd0, 1'b0, none});
        directed.push_back('{32'd65536, 1'b0, none});
        directed.push_back('{32'hFFFF_FFFF, 1'b0, none});
        directed.push_back('{32'd1, 1'b0, none});
        directed.push_back('{32'h8000_0000, 1'b0, none});
        directed.push_back('{32'h0001_0000 >> 2, 1'b0, none});
        directed.push_back('{32'h0000_8000, 1'b0, none});
        foreach (directed[i])
            send_time(directed[i].t, directed[i].known, directed[i].res);
        drain();

        // saturation: full amplitude, top frequency, all terms
        write_reg(ssd_pkg::REG_AMPLITUDE, 24'h7FFF);
        write_reg(ssd_pkg::REG_ANGULAR_FREQUENCY, 24'hFFFFFF);
        write_reg(ssd_pkg::REG_PHASE_OFFSET, 24'h7FFFF);
        write_reg(ssd_pkg::REG_ORDER, 24'd4);
        directed.delete();
        directed.push_back('{32'd0, 1'b0, none});
        directed.push_back('{32'hFFFF_FFFF, 1'b0, none});
        directed.push_back('{32'd12345, 1'b0, none});
        foreach (directed[i])
            send_time(directed[i].t, directed[i].known, directed[i].res);
        drain();

        // most negative amplitude and phase, order zero acts as one
        write_reg(ssd_pkg::REG_AMPLITUDE, 24'h8000);
        write_reg(ssd_pkg::REG_PHASE_OFFSET, 24'h80000);
        write_reg(ssd_pkg::REG_ORDER, 24'd0);
        send_time(32'd0, 1'b0, none);
        send_time(32'h0003_0000, 1'b0, none);
        drain();
        write_reg(ssd_pkg::REG_ORDER, 24'd7);
        write_reg(ssd_pkg::REG_ANGULAR_FREQUENCY, 24'd0);
        send_time(32'h1234_5678, 1'b0, none);
        send_time(32'hFFFF_FFFF, 1'b0, none);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(ssd_pkg::REG_AMPLITUDE, 24'($urandom));
            write_reg(ssd_pkg::REG_ANGULAR_FREQUENCY, phase == 0 ? 24'hFFFFFF :
                      phase == 1 ? 24'd0 : 24'($urandom_range(0, 24'hFFFFFF)));
            write_reg(ssd_pkg::REG_PHASE_OFFSET, 24'($urandom));
            write_reg(ssd_pkg::REG_ORDER, 24'(phase % 8));
            random_burst(150, 1'b1);
            drain();
        end
        write_reg(ssd_pkg::REG_ORDER, 24'd4);
        random_burst(150, 1'b0);
        drain();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* sim.f */
src/ssd_pkg.sv
src/sine_source_with_derivatives.sv
tb/sv/tb_sine_source_with_derivatives.sv
